/* hdl/rwcm_pkg.sv */
// rwcm_pkg: shared constants, types and the arctangent table of the ripple warp
// coordinate map. Used by rwcm_cordic and the top level; has no dependencies.
package rwcm_pkg;

  // angle and trig fixed-point formats
  localparam int ANG_FRAC  = 13;        // angles in Q3.13 radians
  localparam int TRIG_FRAC = 14;        // sine and cosine in Q2.14
  localparam int Z_W       = 16;        // signed angle accumulator width
  localparam int XY_W      = 18;        // signed cordic vector width
  localparam int CORDIC_STEPS = 14;

  localparam int PI_Q13            = 25736;
  localparam int TWO_PI_Q13        = 51472;
  localparam int HALF_PI_Q13       = 12868;
  localparam int THREE_HALF_PI_Q13 = 38604;
  localparam int CORDIC_K_Q14      = 9949;
  localparam int TENTH_Q16         = 6554;
  localparam int TENTH_SHIFT       = 17;

  // ratio, frequency and argument widths
  localparam int RATIO_W   = 14;        // ratio in Q.13, up to 16383
  localparam int FREQ_W    = 16;
  localparam int FREQ_FRAC = 8;
  localparam int PHASE_W   = 9;
  localparam int ARG_W     = RATIO_W + FREQ_W - FREQ_FRAC + 1;
  localparam int AMOD_W    = 16;        // argument after reduction, below two pi

  // phase * pi / 180 as phase * 6434 / 45, the divide by 45 by reciprocal
  localparam int PH_MUL    = 6434;
  localparam int PH_MUL_W  = PHASE_W + 13;
  localparam int DIV45_M   = 5965233;
  localparam int DIV45_M_W = 23;
  localparam int DIV45_SH  = 28;
  localparam int PH_TERM_W = 17;

  // argument modulo two pi by reciprocal, one correction afterwards
  localparam int MOD_M     = 83442;
  localparam int MOD_M_W   = 17;
  localparam int MOD_SH    = 32;
  localparam int MOD_Q_W   = ARG_W + MOD_M_W - MOD_SH;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_RADIUS     = 3'd2,
    CFG_FREQ       = 3'd3,
    CFG_PHASE      = 3'd4,
    CFG_IMG_WIDTH  = 3'd5,
    CFG_IMG_HEIGHT = 3'd6
  } cfg_idx_t;

  // rounded arctangent of 2^-i in Q3.13
  function automatic logic signed [Z_W-1:0] atan_q13(input int i);
    logic signed [Z_W-1:0] v;
    v = '0;
    unique case (i)
      0:  v = 16'sd6434;
      1:  v = 16'sd3798;
      2:  v = 16'sd2007;
      3:  v = 16'sd1019;
      4:  v = 16'sd511;
      5:  v = 16'sd256;
      6:  v = 16'sd128;
      7:  v = 16'sd64;
      8:  v = 16'sd32;
      9:  v = 16'sd16;
      10: v = 16'sd8;
      11: v = 16'sd4;
      12: v = 16'sd2;
      13: v = 16'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/rwcm_sqrt.sv */
// rwcm_sqrt: pipelined integer square root, one result bit per register stage.
// Depends on nothing but its parameters; a side vector travels along unchanged.
module rwcm_sqrt #(
  parameter int IW = 41,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [IW-1:0]         in_rad,
  input  logic [SW-1:0]         in_side,
  output logic                  out_valid,
  output logic [(IW+1)/2-1:0]   out_root,
  output logic [SW-1:0]         out_side
);

  localparam int NP  = (IW + 1) / 2;
  localparam int PW  = 2 * NP;
  localparam int RMW = NP + 2;

  logic            v_r    [NP];
  logic [PW-1:0]   rad_r  [NP];
  logic [RMW-1:0]  rem_r  [NP];
  logic [NP-1:0]   root_r [NP];
  logic [SW-1:0]   side_r [NP];

  for (genvar k = 0; k < NP; k++) begin : g_stage
    logic           vi;
    logic [PW-1:0]  radi;
    logic [RMW-1:0] remi;
    logic [NP-1:0]  rooti;
    logic [SW-1:0]  si;
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;
    logic           ge;

    // stage input: port for the first stage, previous register otherwise
    if (k == 0) begin : g_first
      assign vi    = in_valid;
      assign radi  = PW'(in_rad);
      assign remi  = '0;
      assign rooti = '0;
      assign si    = in_side;
    end else begin : g_next
      assign vi    = v_r[k-1];
      assign radi  = rad_r[k-1];
      assign remi  = rem_r[k-1];
      assign rooti = root_r[k-1];
      assign si    = side_r[k-1];
    end

    // bring down the next bit pair and try the next root bit
    assign cur   = {remi[RMW-3:0], radi[PW-1:PW-2]};
    assign trial = {rooti, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= radi << 2;
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {rooti[NP-2:0], ge};
        side_r[k] <= si;
      end
    end
  end

  assign out_valid = v_r[NP-1];
  assign out_root  = root_r[NP-1];
  assign out_side  = side_r[NP-1];

endmodule

/* hdl/rwcm_div.sv */
// rwcm_div: pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QW bits; depends on nothing but its parameters.
module rwcm_div #(
  parameter int NW = 26,
  parameter int DW = 12,
  parameter int QW = 14,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          v_r    [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] lq_r   [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vi;
    logic [DW-1:0] remi;
    logic [QW-1:0] lqi;
    logic [SW-1:0] si;
    logic [DW:0]   cur;
    logic [DW:0]   dif;
    logic          ge;

    // upper numerator bits start the remainder, lower ones shift in
    if (k == 0) begin : g_first
      assign vi   = in_valid;
      assign remi = DW'(in_num[NW-1:QW]);
      assign lqi  = in_num[QW-1:0];
      assign si   = in_side;
    end else begin : g_next
      assign vi   = v_r[k-1];
      assign remi = rem_r[k-1];
      assign lqi  = lq_r[k-1];
      assign si   = side_r[k-1];
    end

    // trial subtract of the divisor
    assign cur = {remi, lqi[QW-1]};
    assign dif = cur - {1'b0, in_den};
    assign ge  = (cur >= {1'b0, in_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? dif[DW-1:0] : cur[DW-1:0];
        lq_r[k]   <= {lqi[QW-2:0], ge};
        side_r[k] <= si;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quot  = lq_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

/* hdl/rwcm_cordic.sv */
// rwcm_cordic: pipelined rotation cordic giving cosine and sine in Q2.14,
// one iteration per register stage. Depends on rwcm_pkg for formats and table.
module rwcm_cordic #(
  parameter int SW = 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [rwcm_pkg::Z_W-1:0]      in_z,
  input  logic [SW-1:0]                        in_side,
  output logic                                 out_valid,
  output logic signed [rwcm_pkg::XY_W-1:0]     out_cos,
  output logic signed [rwcm_pkg::XY_W-1:0]     out_sin,
  output logic [SW-1:0]                        out_side
);

  localparam int N  = rwcm_pkg::CORDIC_STEPS;
  localparam int XW = rwcm_pkg::XY_W;
  localparam int ZW = rwcm_pkg::Z_W;

  logic                 v_r    [N];
  logic signed [XW-1:0] x_r    [N];
  logic signed [XW-1:0] y_r    [N];
  logic signed [ZW-1:0] z_r    [N];
  logic [SW-1:0]        side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                 vi;
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic [SW-1:0]        si;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] ang;

    // the first stage starts from the gain-corrected unit vector
    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign xi = XW'(rwcm_pkg::CORDIC_K_Q14);
      assign yi = '0;
      assign zi = in_z;
      assign si = in_side;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
      assign si = side_r[k-1];
    end

    // floor shifts and the table angle of this step
    assign xs  = xi >>> k;
    assign ys  = yi >>> k;
    assign ang = rwcm_pkg::atan_q13(k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    // rotate towards zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[ZW-1]) begin
          x_r[k] <= xi - ys;
          y_r[k] <= yi + xs;
          z_r[k] <= zi - ang;
        end else begin
          x_r[k] <= xi + ys;
          y_r[k] <= yi - xs;
          z_r[k] <= zi + ang;
        end
        side_r[k] <= si;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_cos   = x_r[N-1];
  assign out_sin   = y_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

/* hdl/ripple_warp_coordinate_map.sv */
// ripple_warp_coordinate_map: polar ripple warp, destination to source coordinate.
// Top level; depends on rwcm_pkg, rwcm_sqrt, rwcm_div and rwcm_cordic.
//
// Usage
//   in_*  : one destination pixel per transfer, tdata = {dst_y, dst_x}.
//   out_* : one source coordinate per transfer, tdata = {src_y, src_x} in
//           Q(COORD_BITS).(FRAC_BITS), tuser = inside_res.
//   cfg_* : register writes (index, data), always ready; write only while no
//           pixel is in flight.
//   Throughput is one pixel per clock while the receiver does not stall. The
//   pipeline depth is set by the offset, square and circle-test stages, the
//   square root, the divider, the argument stages, two cordic pipelines,
//   the twist and rotation stages and the output register.
//   The whole pipeline advances whenever the output register is empty or
//   being taken; when the receiver stalls everything freezes in place and
//   in_tready drops, so nothing is lost or repeated.
//   Synchronous reset empties the pipeline and loads the register defaults
//   (centre 0,0, radius 100, frequency 10.0, phase 0, image 640 x 480).
module ripple_warp_coordinate_map #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // dst_x, dst_y (lowest bits first), zero padded
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]            in_tdata,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // src_x, src_y (lowest bits first), zero padded
  output logic [((2*(COORD_BITS+FRAC_BITS)+7)/8)*8-1:0] out_tdata,
  // inside_res
  output logic                                         out_tuser,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [rwcm_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [((COORD_BITS+1 > 16) ? COORD_BITS+1 : 16)-1:0] cfg_data
);

  localparam int CW   = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = CW + 1;
  localparam int D2W  = 2 * CW + 1;
  localparam int SIW  = D2W + 2 * F;
  localparam int RW   = (SIW + 1) / 2;
  localparam int NW   = RW + rwcm_pkg::ANG_FRAC - F;
  localparam int OW   = CW + F;
  localparam int OTW  = ((2 * OW + 7) / 8) * 8;
  localparam int SW   = 1 + 2 * DW + 2 * CW;
  localparam int XW   = rwcm_pkg::XY_W;
  localparam int ZW   = rwcm_pkg::Z_W;
  localparam int MW   = DW + XW;
  localparam int PW   = MW + 2;
  localparam int SHF  = rwcm_pkg::TRIG_FRAC - F;
  localparam int QW   = rwcm_pkg::RATIO_W;
  localparam int AW   = rwcm_pkg::ARG_W;
  localparam int AMW  = rwcm_pkg::AMOD_W;

  // side vector layout {inside, dx, dy, px, py}
  localparam int PY_LO = 0;
  localparam int PX_LO = CW;
  localparam int DY_LO = 2 * CW;
  localparam int DX_LO = 2 * CW + DW;
  localparam int IN_B  = SW - 1;

  logic en;

  // configuration registers
  logic [CW-1:0]                    center_x_r;
  logic [CW-1:0]                    center_y_r;
  logic [CW-1:0]                    radius_r;
  logic [rwcm_pkg::FREQ_W-1:0]      freq_r;
  logic [rwcm_pkg::PHASE_W-1:0]     phase_r;
  logic [CW:0]                      width_r;
  logic [CW:0]                      height_r;
  logic [rwcm_pkg::PH_MUL_W-1:0]    ph_mul_r;
  logic [rwcm_pkg::PH_TERM_W-1:0]   ph_term_r;
  logic [rwcm_pkg::PH_MUL_W+rwcm_pkg::DIV45_M_W-1:0] ph_prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= CW'(100);
      freq_r     <= rwcm_pkg::FREQ_W'(2560);
      phase_r    <= '0;
      width_r    <= DW'(640);
      height_r   <= DW'(480);
    end else if (cfg_valid) begin
      unique case (rwcm_pkg::cfg_idx_t'(cfg_index))
        rwcm_pkg::CFG_CENTER_X:   center_x_r <= cfg_data[CW-1:0];
        rwcm_pkg::CFG_CENTER_Y:   center_y_r <= cfg_data[CW-1:0];
        rwcm_pkg::CFG_RADIUS:     radius_r   <= cfg_data[CW-1:0];
        rwcm_pkg::CFG_FREQ:       freq_r     <= cfg_data[rwcm_pkg::FREQ_W-1:0];
        rwcm_pkg::CFG_PHASE:      phase_r    <= cfg_data[rwcm_pkg::PHASE_W-1:0];
        rwcm_pkg::CFG_IMG_WIDTH:  width_r    <= cfg_data[CW:0];
        rwcm_pkg::CFG_IMG_HEIGHT: height_r   <= cfg_data[CW:0];
        default: ;
      endcase
    end
  end

  // phase term phase * 6434 / 45, two registered steps behind the register
  assign ph_prod = ph_mul_r * rwcm_pkg::DIV45_M_W'(rwcm_pkg::DIV45_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_mul_r  <= '0;
      ph_term_r <= '0;
    end else begin
      ph_mul_r  <= rwcm_pkg::PH_MUL_W'(phase_r * 13'(rwcm_pkg::PH_MUL));
      ph_term_r <= rwcm_pkg::PH_TERM_W'(ph_prod >> rwcm_pkg::DIV45_SH);
    end
  end

  // whole pipeline moves when the output register can take a result
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 0: offsets from the centre
  logic                 s0_v_r;
  logic signed [DW-1:0] s0_dx_r, s0_dy_r;
  logic [CW-1:0]        s0_px_r, s0_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_px_r <= in_tdata[CW-1:0];
      s0_py_r <= in_tdata[2*CW-1:CW];
      s0_dx_r <= $signed({1'b0, in_tdata[CW-1:0]}) - $signed({1'b0, center_x_r});
      s0_dy_r <= $signed({1'b0, in_tdata[2*CW-1:CW]}) - $signed({1'b0, center_y_r});
    end
  end

  // stage 1: squares
  logic                 s1_v_r;
  logic signed [DW-1:0] s1_dx_r, s1_dy_r;
  logic [CW-1:0]        s1_px_r, s1_py_r;
  logic [2*CW-1:0]      s1_dxx_r, s1_dyy_r, s1_rr_r;
  logic signed [2*DW-1:0] sq_x, sq_y;

  assign sq_x = s0_dx_r * s0_dx_r;
  assign sq_y = s0_dy_r * s0_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r  <= s0_dx_r;
      s1_dy_r  <= s0_dy_r;
      s1_px_r  <= s0_px_r;
      s1_py_r  <= s0_py_r;
      s1_dxx_r <= sq_x[2*CW-1:0];
      s1_dyy_r <= sq_y[2*CW-1:0];
      s1_rr_r  <= radius_r * radius_r;
    end
  end

  // stage 2: squared distance and circle test
  logic            s2_v_r;
  logic [D2W-1:0]  s2_d2_r;
  logic [SW-1:0]   s2_side_r;
  logic [D2W-1:0]  d2_sum;

  assign d2_sum = D2W'(s1_dxx_r) + D2W'(s1_dyy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d2_r   <= d2_sum;
      s2_side_r <= {(d2_sum <= D2W'(s1_rr_r)), s1_dx_r, s1_dy_r, s1_px_r, s1_py_r};
    end
  end

  // distance r in Q.F
  logic            sq_v;
  logic [RW-1:0]   sq_root;
  logic [SW-1:0]   sq_side;

  rwcm_sqrt #(.IW(SIW), .SW(SW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_v_r),
    .in_rad    ({s2_d2_r, {(2*F){1'b0}}}),
    .in_side   (s2_side_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ratio r / radius in Q.13
  logic            dv_v;
  logic [QW-1:0]   dv_quot;
  logic [SW-1:0]   dv_side;

  rwcm_div #(.NW(NW), .DW(CW), .QW(QW), .SW(SW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_num    (NW'(sq_root) << (rwcm_pkg::ANG_FRAC - F)),
    .in_den    (radius_r),
    .in_side   (sq_side),
    .out_valid (dv_v),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // stage 3: ratio times frequency (zero radius gives zero ratio)
  logic                                        s3_v_r;
  logic [QW+rwcm_pkg::FREQ_W-1:0]              s3_prod_r;
  logic [SW-1:0]                               s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_prod_r <= (radius_r == '0) ? '0 : dv_quot * freq_r;
      s3_side_r <= dv_side;
    end
  end

  // stage 4: argument
  logic            s4_v_r;
  logic [AW-1:0]   s4_arg_r;
  logic [SW-1:0]   s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_arg_r  <= AW'(s3_prod_r >> rwcm_pkg::FREQ_FRAC) + AW'(ph_term_r);
      s4_side_r <= s3_side_r;
    end
  end

  // stage 5: quotient estimate of argument / two pi
  logic                           s5_v_r;
  logic [AW-1:0]                  s5_arg_r;
  logic [rwcm_pkg::MOD_Q_W-1:0]   s5_q_r;
  logic [SW-1:0]                  s5_side_r;
  logic [AW+rwcm_pkg::MOD_M_W-1:0] mod_prod;

  assign mod_prod = s4_arg_r * rwcm_pkg::MOD_M_W'(rwcm_pkg::MOD_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_arg_r  <= s4_arg_r;
      s5_q_r    <= mod_prod[AW+rwcm_pkg::MOD_M_W-1:rwcm_pkg::MOD_SH];
      s5_side_r <= s4_side_r;
    end
  end

  // stage 6: remainder, at most one two pi too large
  logic            s6_v_r;
  logic [AW-1:0]   s6_a_r;
  logic [SW-1:0]   s6_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_a_r    <= s5_arg_r - AW'(s5_q_r * AMW'(rwcm_pkg::TWO_PI_Q13));
      s6_side_r <= s5_side_r;
    end
  end

  // stage 7: final correction of the remainder
  logic            s7_v_r;
  logic [AMW-1:0]  s7_a_r;
  logic [SW-1:0]   s7_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s6_a_r >= AW'(rwcm_pkg::TWO_PI_Q13)) begin
        s7_a_r <= AMW'(s6_a_r - AW'(rwcm_pkg::TWO_PI_Q13));
      end else begin
        s7_a_r <= AMW'(s6_a_r);
      end
      s7_side_r <= s6_side_r;
    end
  end

  // stage 8: fold into plus or minus half pi, keeping the sine
  logic                  s8_v_r;
  logic signed [ZW-1:0]  s8_z_r;
  logic [SW-1:0]         s8_side_r;
  logic signed [AMW:0]   a_ext;

  assign a_ext = $signed({1'b0, s7_a_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (s7_a_r < AMW'(rwcm_pkg::HALF_PI_Q13)) begin
        s8_z_r <= ZW'(a_ext);
      end else if (s7_a_r < AMW'(rwcm_pkg::THREE_HALF_PI_Q13)) begin
        s8_z_r <= ZW'((AMW+1)'(rwcm_pkg::PI_Q13) - a_ext);
      end else begin
        s8_z_r <= ZW'(a_ext - (AMW+1)'(rwcm_pkg::TWO_PI_Q13));
      end
      s8_side_r <= s7_side_r;
    end
  end

  // sine of the ripple argument
  logic                  c1_v;
  logic signed [XW-1:0]  c1_cos, c1_sin;
  logic [SW-1:0]         c1_side;

  rwcm_cordic #(.SW(SW)) u_cordic_arg (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s8_v_r),
    .in_z      (s8_z_r),
    .in_side   (s8_side_r),
    .out_valid (c1_v),
    .out_cos   (c1_cos),
    .out_sin   (c1_sin),
    .out_side  (c1_side)
  );

  // stage 9: twist angle t = 0.1 * sin
  logic                  s9_v_r;
  logic signed [ZW-1:0]  s9_t_r;
  logic [SW-1:0]         s9_side_r;
  logic signed [XW+15:0] t_prod;

  assign t_prod = c1_sin * $signed(16'(rwcm_pkg::TENTH_Q16));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r <= 1'b0;
    end else if (en) begin
      s9_v_r <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_t_r    <= ZW'(t_prod >>> rwcm_pkg::TENTH_SHIFT);
      s9_side_r <= c1_side;
    end
  end

  // cosine and sine of the twist angle
  logic                  c2_v;
  logic signed [XW-1:0]  c2_cos, c2_sin;
  logic [SW-1:0]         c2_side;

  rwcm_cordic #(.SW(SW)) u_cordic_twist (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s9_v_r),
    .in_z      (s9_t_r),
    .in_side   (s9_side_r),
    .out_valid (c2_v),
    .out_cos   (c2_cos),
    .out_sin   (c2_sin),
    .out_side  (c2_side)
  );

  // stage 10: rotation products
  logic                  s10_v_r;
  logic signed [MW-1:0]  s10_xc_r, s10_ys_r, s10_yc_r, s10_xs_r;
  logic [SW-1:0]         s10_side_r;
  logic signed [DW-1:0]  c2_dx, c2_dy;

  assign c2_dx = $signed(c2_side[DX_LO +: DW]);
  assign c2_dy = $signed(c2_side[DY_LO +: DW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_v_r <= 1'b0;
    end else if (en) begin
      s10_v_r <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_xc_r   <= c2_dx * c2_cos;
      s10_ys_r   <= c2_dy * c2_sin;
      s10_yc_r   <= c2_dy * c2_cos;
      s10_xs_r   <= c2_dx * c2_sin;
      s10_side_r <= c2_side;
    end
  end

  // stage 11: rotated offset scaled to Q.F plus the centre
  logic                  s11_v_r;
  logic signed [PW-1:0]  s11_rx_r, s11_ry_r;
  logic [SW-1:0]         s11_side_r;
  logic signed [PW-1:0]  rot_x, rot_y, cen_x, cen_y;

  assign rot_x = (PW'(s10_xc_r) - PW'(s10_ys_r)) >>> SHF;
  assign rot_y = (PW'(s10_yc_r) + PW'(s10_xs_r)) >>> SHF;
  assign cen_x = $signed(PW'({center_x_r, {F{1'b0}}}));
  assign cen_y = $signed(PW'({center_y_r, {F{1'b0}}}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_v_r <= 1'b0;
    end else if (en) begin
      s11_v_r <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_rx_r   <= cen_x + rot_x;
      s11_ry_r   <= cen_y + rot_y;
      s11_side_r <= s10_side_r;
    end
  end

  // clamp limits from the image size (zero acts as one, oversize as full range)
  logic [CW:0]    w_eff, h_eff;
  logic [CW-1:0]  w_last, h_last;
  logic [OW-1:0]  cx, cy;
  logic [CW:0]    w_m1, h_m1;

  always_comb begin
    priority if (width_r == '0)   w_eff = DW'(1);
    else if (width_r[CW])         w_eff = {1'b1, {CW{1'b0}}};
    else                          w_eff = width_r;
    priority if (height_r == '0)  h_eff = DW'(1);
    else if (height_r[CW])        h_eff = {1'b1, {CW{1'b0}}};
    else                          h_eff = height_r;
  end

  assign w_m1   = w_eff - DW'(1);
  assign h_m1   = h_eff - DW'(1);
  assign w_last = w_m1[CW-1:0];
  assign h_last = h_m1[CW-1:0];

  always_comb begin
    priority if (s11_rx_r < 0) begin
      cx = '0;
    end else if (s11_rx_r >= $signed(PW'({w_eff, {F{1'b0}}}))) begin
      cx = {w_last, {F{1'b0}}};
    end else begin
      cx = s11_rx_r[OW-1:0];
    end
    priority if (s11_ry_r < 0) begin
      cy = '0;
    end else if (s11_ry_r >= $signed(PW'({h_eff, {F{1'b0}}}))) begin
      cy = {h_last, {F{1'b0}}};
    end else begin
      cy = s11_ry_r[OW-1:0];
    end
  end

  // output register: outside pixels map to themselves
  logic           out_v_r;
  logic           out_in_r;
  logic [OW-1:0]  out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s11_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_in_r <= s11_side_r[IN_B];
      if (s11_side_r[IN_B]) begin
        out_x_r <= cx;
        out_y_r <= cy;
      end else begin
        out_x_r <= {s11_side_r[PX_LO +: CW], {F{1'b0}}};
        out_y_r <= {s11_side_r[PY_LO +: CW], {F{1'b0}}};
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_in_r;
  assign out_tdata  = OTW'({out_y_r, out_x_r});

endmodule
